// ----- hw/rtl/spa_pkg.sv -----
// Shared types and constants for the pair moment accumulator.
// Holds the kernel constant, queue sizing and the queue status struct.
// No dependencies.
`default_nettype none

package spa_pkg;

    // 315/(64*pi) in Q.30
    localparam logic [30:0] KERNEL_Q30   = 31'd1682211420;
    localparam int          KQ_FRAC      = 30;
    // q in Q.30 never exceeds 2^30
    localparam int          KQ_WIDTH     = 31;
    // kernel factor a stays below 2^33
    localparam int          A_WIDTH      = 33;
    localparam int          QUEUE_DEPTH  = 2;

    // entry codes inside one row: columns 0..5, then the density term
    localparam logic [2:0]  ENT_LAST_COL = 3'd5;
    localparam logic [2:0]  ENT_DENS     = 3'd6;
    localparam logic [1:0]  ROW_FIRST    = 2'd0;
    localparam logic [1:0]  ROW_LAST     = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } spa_qstat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sph_pair_moment_accumulate.sv -----
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// pair in   | start, busy          | ref_offset_*, disp_diff_*, radius_*, mass_*
// row out   | result_valid (pulse) | node_side, row_index, *_inc_*, last_row
//
// A pair is taken when start is high and busy is low; the front end squares the
// offset and parks the pair in a two-entry queue, so new pairs keep coming while one
// is worked. The back end runs a bit-serial divide for the kernel factor of each node,
// then multiplies and divides each of the 19 entries in turn; for a node outside the kernel
// it skips the kernel divide and stores zero for each entry without a divide.
// busy rises only while the front register holds a pair and the queue is full.
// Each row result is shown for one cycle on result_valid; the receiver cannot stall.
// Reset clears all control.
// Top level: pair moment accumulator; depends on spa_pkg, spa_front, spa_queue, spa_back.
`default_nettype none

module sph_pair_moment_accumulate
    import spa_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int RESULT_WIDTH = 48
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] ref_offset_x,
    input  wire logic signed [COORD_WIDTH-1:0] ref_offset_y,
    input  wire logic signed [COORD_WIDTH-1:0] ref_offset_z,
    input  wire logic signed [COORD_WIDTH-1:0] disp_diff_x,
    input  wire logic signed [COORD_WIDTH-1:0] disp_diff_y,
    input  wire logic signed [COORD_WIDTH-1:0] disp_diff_z,
    input  wire logic        [COORD_WIDTH-2:0] radius_a,
    input  wire logic        [COORD_WIDTH-2:0] radius_b,
    input  wire logic        [COORD_WIDTH-1:0] mass_a,
    input  wire logic        [COORD_WIDTH-1:0] mass_b,
    output logic                               result_valid,
    output logic                               node_side,
    output logic        [1:0]                  row_index,
    output logic signed [RESULT_WIDTH-1:0]     moment_inc_c0,
    output logic signed [RESULT_WIDTH-1:0]     moment_inc_c1,
    output logic signed [RESULT_WIDTH-1:0]     moment_inc_c2,
    output logic signed [RESULT_WIDTH-1:0]     jmat_inc_c0,
    output logic signed [RESULT_WIDTH-1:0]     jmat_inc_c1,
    output logic signed [RESULT_WIDTH-1:0]     jmat_inc_c2,
    output logic        [RESULT_WIDTH-2:0]     density_inc,
    output logic                               last_row
);

    localparam int EW = 12*COORD_WIDTH - 2;

    spa_qstat_t    qstat;
    logic          push, pop;
    logic [EW-1:0] push_data, pop_data;

    spa_front #(.CW(COORD_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .ref_offset_x (ref_offset_x),
        .ref_offset_y (ref_offset_y),
        .ref_offset_z (ref_offset_z),
        .disp_diff_x  (disp_diff_x),
        .disp_diff_y  (disp_diff_y),
        .disp_diff_z  (disp_diff_z),
        .radius_a     (radius_a),
        .radius_b     (radius_b),
        .mass_a       (mass_a),
        .mass_b       (mass_b),
        .qstat        (qstat),
        .push         (push),
        .push_data    (push_data)
    );

    spa_queue #(.WIDTH(EW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    spa_back #(.CW(COORD_WIDTH), .RW(RESULT_WIDTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .pop_data      (pop_data),
        .pop           (pop),
        .result_valid  (result_valid),
        .node_side     (node_side),
        .row_index     (row_index),
        .moment_inc_c0 (moment_inc_c0),
        .moment_inc_c1 (moment_inc_c1),
        .moment_inc_c2 (moment_inc_c2),
        .jmat_inc_c0   (jmat_inc_c0),
        .jmat_inc_c1   (jmat_inc_c1),
        .jmat_inc_c2   (jmat_inc_c2),
        .density_inc   (density_inc),
        .last_row      (last_row)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/spa_queue.sv -----
// Two-entry queue between front end and back end.
// Depends on spa_pkg for depth and status struct.
`default_nettype none

module spa_queue
    import spa_pkg::*;
#(
    parameter int WIDTH = 286
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output spa_qstat_t            qstat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/spa_front.sv -----
// Front end: takes one pair transaction, squares the offset and packs the queue entry.
// Depends on spa_pkg for the queue status struct.
`default_nettype none

module spa_front
    import spa_pkg::*;
#(
    parameter int CW = 24
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [CW-1:0] ref_offset_x,
    input  wire logic signed [CW-1:0] ref_offset_y,
    input  wire logic signed [CW-1:0] ref_offset_z,
    input  wire logic signed [CW-1:0] disp_diff_x,
    input  wire logic signed [CW-1:0] disp_diff_y,
    input  wire logic signed [CW-1:0] disp_diff_z,
    input  wire logic        [CW-2:0] radius_a,
    input  wire logic        [CW-2:0] radius_b,
    input  wire logic        [CW-1:0] mass_a,
    input  wire logic        [CW-1:0] mass_b,
    input  wire spa_qstat_t           qstat,
    output logic                      push,
    output logic      [12*CW-3:0]     push_data
);

    logic                 valid_reg, valid_next;
    logic                 accept;
    logic signed [CW-1:0] dx_reg, dy_reg, dz_reg, gx_reg, gy_reg, gz_reg;
    logic        [CW-2:0] ra_reg, rb_reg;
    logic        [CW-1:0] ma_reg, mb_reg;
    logic [2*CW-2:0]      sqx_reg, sqy_reg, sqz_reg;
    logic signed [2*CW-1:0] sqx, sqy, sqz;
    logic [2*CW-1:0]      r2;

    assign busy   = valid_reg && qstat.full;
    assign accept = start && !busy;
    assign push   = valid_reg && !qstat.full;

    // hold the stage while the queue is full
    assign valid_next = accept || (valid_reg && qstat.full);

    assign sqx = ref_offset_x * ref_offset_x;
    assign sqy = ref_offset_y * ref_offset_y;
    assign sqz = ref_offset_z * ref_offset_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg  <= ref_offset_x;
            dy_reg  <= ref_offset_y;
            dz_reg  <= ref_offset_z;
            gx_reg  <= disp_diff_x;
            gy_reg  <= disp_diff_y;
            gz_reg  <= disp_diff_z;
            ra_reg  <= radius_a;
            rb_reg  <= radius_b;
            ma_reg  <= mass_a;
            mb_reg  <= mass_b;
            sqx_reg <= sqx[2*CW-2:0];
            sqy_reg <= sqy[2*CW-2:0];
            sqz_reg <= sqz[2*CW-2:0];
        end
    end

    assign r2 = (2*CW)'(sqx_reg) + (2*CW)'(sqy_reg) + (2*CW)'(sqz_reg);

    assign push_data = {dx_reg, dy_reg, dz_reg, gx_reg, gy_reg, gz_reg,
                        ra_reg, rb_reg, ma_reg, mb_reg, r2};

endmodule

`default_nettype wire

// ----- hw/rtl/spa_back.sv -----
// Back end: poly6 kernel factor, per-entry multiply and bit-serial divide, row output.
// Depends on spa_pkg for kernel constants, entry codes and the queue status struct.
`default_nettype none

module spa_back
    import spa_pkg::*;
#(
    parameter int CW = 24,
    parameter int RW = 48
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spa_qstat_t        qstat,
    input  wire logic [12*CW-3:0]  pop_data,
    output logic                   pop,
    output logic                   result_valid,
    output logic                   node_side,
    output logic        [1:0]      row_index,
    output logic signed [RW-1:0]   moment_inc_c0,
    output logic signed [RW-1:0]   moment_inc_c1,
    output logic signed [RW-1:0]   moment_inc_c2,
    output logic signed [RW-1:0]   jmat_inc_c0,
    output logic signed [RW-1:0]   jmat_inc_c1,
    output logic signed [RW-1:0]   jmat_inc_c2,
    output logic        [RW-2:0]   density_inc,
    output logic                   last_row
);

    localparam int MW  = (2*CW - 1 > CW + 16) ? 2*CW - 1 : CW + 16;
    localparam int ML  = (MW + 1) / 2;
    localparam int MH  = MW - ML;
    localparam int NW  = MW + A_WIDTH;
    localparam int HW  = 3*CW - 3;
    localparam int H2W = 2*CW - 2;
    localparam int DCW = $clog2(RW);
    localparam int KCW = $clog2(KQ_WIDTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_H2    = 10'b0000000010,
        S_KCHK  = 10'b0000000100,
        S_KDIV  = 10'b0000001000,
        S_KPOLY = 10'b0000010000,
        S_EMUL0 = 10'b0000100000,
        S_EMUL1 = 10'b0001000000,
        S_EMUL2 = 10'b0010000000,
        S_ECHK  = 10'b0100000000,
        S_EDIV  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // pair fields
    logic signed [CW-1:0] dx_reg, dy_reg, dz_reg, gx_reg, gy_reg, gz_reg;
    logic        [CW-2:0] ra_reg, rb_reg;
    logic        [CW-1:0] ma_reg, mb_reg;
    logic [2*CW-1:0]      r2_reg;
    logic signed [CW-1:0] u_dx, u_dy, u_dz, u_gx, u_gy, u_gz;
    logic        [CW-2:0] u_ra, u_rb;
    logic        [CW-1:0] u_ma, u_mb;
    logic [2*CW-1:0]      u_r2;

    // sequencing
    logic                 side_reg;
    logic [1:0]           row_reg;
    logic [2:0]           ent_reg;
    logic                 emit_reg;

    // kernel
    logic [CW-2:0]        h_reg;
    logic [H2W-1:0]       h2_reg;
    logic [2*CW-2:0]      krem_reg;
    logic [KQ_WIDTH-1:0]  kq_reg, q2_reg, q3_reg;
    logic [KCW-1:0]       kcnt_reg;
    logic [2:0]           ph_reg;
    logic [A_WIDTH-1:0]   a_reg;
    logic [H2W-1:0]       h3lo_reg;
    logic [HW-1:0]        h3_reg;

    // entry datapath
    logic [MW-1:0]        mag_reg;
    logic                 neg_reg;
    logic [ML+A_WIDTH-1:0] plo_reg;
    logic [NW-1:0]        num_reg;
    logic [HW-1:0]        rem_reg;
    logic [RW-1:0]        nlo_reg, quo_reg;
    logic [DCW-1:0]       dcnt_reg;

    // output registers
    logic                 valid_reg;
    logic                 side_out_reg, last_out_reg;
    logic [1:0]           row_out_reg;
    logic signed [RW-1:0] mc0_reg, mc1_reg, mc2_reg, jc0_reg, jc1_reg, jc2_reg;
    logic [RW-2:0]        dens_reg;

    logic signed [CW-1:0]   op_row, op_col;
    logic signed [2*CW-1:0] eprod;
    logic [2*CW-1:0]        eprod_mag;
    logic                   kge;
    logic [2*CW-2:0]        ksub;
    logic [61:0]            kmul;
    logic [H2W-1:0]         h3mul;
    logic [ML+A_WIDTH-1:0]  plo;
    logic [MH+A_WIDTH-1:0]  phi;
    logic [NW-1:0]          num_hi;
    logic [HW:0]            trial;
    logic                   dge;
    logic [RW-1:0]          quo_next;
    logic                   store_en, store_ovf;
    logic [RW-1:0]          store_q;
    logic [RW-1:0]          store_val;
    logic                   row_done;

    function automatic logic [RW-1:0] sat_mag(input logic [RW-1:0] q, input logic neg,
                                              input logic ovf);
        logic [RW-1:0] lim;
        logic [RW-1:0] v;
        lim = RW'(1) << (RW - 1);
        if (neg)
        begin
            v = (ovf || q > lim) ? lim : q;
            sat_mag = '0 - v;
        end
        else
        begin
            sat_mag = (ovf || q > lim - 1'b1) ? lim - 1'b1 : q;
        end
    endfunction

    assign {u_dx, u_dy, u_dz, u_gx, u_gy, u_gz, u_ra, u_rb, u_ma, u_mb, u_r2} = pop_data;

    assign pop = (state_reg == S_IDLE) && !qstat.empty;

    // operand selection for the current entry
    always_comb
    begin
        case (row_reg)
            2'd0:    op_row = dx_reg;
            2'd1:    op_row = dy_reg;
            default: op_row = dz_reg;
        endcase
        case (ent_reg)
            3'd0:    op_col = dx_reg;
            3'd1:    op_col = dy_reg;
            3'd2:    op_col = dz_reg;
            3'd3:    op_col = gx_reg;
            3'd4:    op_col = gy_reg;
            3'd5:    op_col = gz_reg;
            default: op_col = '0;
        endcase
    end

    assign eprod     = op_row * op_col;
    assign eprod_mag = eprod[2*CW-1] ? (2*CW)'(-eprod) : (2*CW)'(eprod);

    assign kge  = krem_reg >= (2*CW-1)'(h2_reg);
    assign ksub = krem_reg - (2*CW-1)'(h2_reg);

    always_comb
    begin
        case (ph_reg)
            3'd0:    kmul = kq_reg * kq_reg;
            3'd1:    kmul = q2_reg * kq_reg;
            default: kmul = q3_reg * KERNEL_Q30;
        endcase
    end

    assign h3mul = (ph_reg == 3'd3) ? h2_reg[CW-2:0] * h_reg : h2_reg[H2W-1:CW-1] * h_reg;

    assign plo    = mag_reg[ML-1:0] * a_reg;
    assign phi    = mag_reg[MW-1:ML] * a_reg;
    assign num_hi = num_reg >> RW;

    assign trial    = {rem_reg, nlo_reg[RW-1]};
    assign dge      = trial >= (HW+1)'(h3_reg);
    assign quo_next = {quo_reg[RW-2:0], dge};

    // one entry result: zero outside kernel, saturate on quotient overflow
    always_comb
    begin
        store_en  = 1'b0;
        store_ovf = 1'b0;
        store_q   = '0;
        if (state_reg == S_ECHK)
        begin
            if (a_reg == '0)
            begin
                store_en = 1'b1;
            end
            else if (num_hi >= NW'(h3_reg))
            begin
                store_en  = 1'b1;
                store_ovf = 1'b1;
            end
        end
        else if (state_reg == S_EDIV && dcnt_reg == DCW'(RW - 1))
        begin
            store_en = 1'b1;
            store_q  = quo_next;
        end
    end

    assign store_val = sat_mag(store_q, neg_reg && (a_reg != '0), store_ovf);
    assign row_done  = (ent_reg == ENT_DENS) ||
                       (ent_reg == ENT_LAST_COL && row_reg != ROW_FIRST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = S_H2;
                end
            end
            S_H2:
            begin
                state_next = S_KCHK;
            end
            S_KCHK:
            begin
                state_next = (r2_reg >= (2*CW)'(h2_reg)) ? S_EMUL0 : S_KDIV;
            end
            S_KDIV:
            begin
                if (kcnt_reg == KCW'(KQ_WIDTH - 1))
                begin
                    state_next = S_KPOLY;
                end
            end
            S_KPOLY:
            begin
                if (ph_reg == 3'd4)
                begin
                    state_next = S_EMUL0;
                end
            end
            S_EMUL0:
            begin
                state_next = S_EMUL1;
            end
            S_EMUL1:
            begin
                state_next = S_EMUL2;
            end
            S_EMUL2:
            begin
                state_next = S_ECHK;
            end
            S_ECHK, S_EDIV:
            begin
                if (store_en)
                begin
                    if (!row_done)
                    begin
                        state_next = S_EMUL0;
                    end
                    else if (row_reg != ROW_LAST)
                    begin
                        state_next = S_EMUL0;
                    end
                    else if (!side_reg)
                    begin
                        state_next = S_H2;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_EDIV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            side_reg  <= 1'b0;
            row_reg   <= '0;
            ent_reg   <= '0;
            ph_reg    <= '0;
            kcnt_reg  <= '0;
            dcnt_reg  <= '0;
            emit_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= store_en && row_done;
            valid_reg <= emit_reg;
            case (state_reg)
                S_IDLE:
                begin
                    side_reg <= 1'b0;
                end
                S_KCHK:
                begin
                    kcnt_reg <= '0;
                    ph_reg   <= '0;
                    row_reg  <= ROW_FIRST;
                    ent_reg  <= '0;
                end
                S_KDIV:
                begin
                    kcnt_reg <= kcnt_reg + 1'b1;
                end
                S_KPOLY:
                begin
                    ph_reg <= ph_reg + 1'b1;
                end
                S_ECHK, S_EDIV:
                begin
                    dcnt_reg <= (state_reg == S_ECHK) ? '0 : dcnt_reg + 1'b1;
                    if (store_en)
                    begin
                        // advance entry, then row, then side
                        if (!row_done)
                        begin
                            ent_reg <= ent_reg + 1'b1;
                        end
                        else
                        begin
                            ent_reg <= '0;
                            if (row_reg != ROW_LAST)
                            begin
                                row_reg <= row_reg + 1'b1;
                            end
                            else
                            begin
                                row_reg  <= ROW_FIRST;
                                side_reg <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dx_reg <= u_dx;
            dy_reg <= u_dy;
            dz_reg <= u_dz;
            gx_reg <= u_gx;
            gy_reg <= u_gy;
            gz_reg <= u_gz;
            ra_reg <= u_ra;
            rb_reg <= u_rb;
            ma_reg <= u_ma;
            mb_reg <= u_mb;
            r2_reg <= u_r2;
        end
        case (state_reg)
            S_H2:
            begin
                h_reg  <= side_reg ? rb_reg : ra_reg;
                h2_reg <= (side_reg ? rb_reg : ra_reg) * (side_reg ? rb_reg : ra_reg);
            end
            S_KCHK:
            begin
                a_reg    <= '0;
                kq_reg   <= '0;
                krem_reg <= (2*CW-1)'(h2_reg - r2_reg[H2W-1:0]);
            end
            S_KDIV:
            begin
                kq_reg   <= {kq_reg[KQ_WIDTH-2:0], kge};
                krem_reg <= (kge ? ksub : krem_reg) << 1;
            end
            S_KPOLY:
            begin
                case (ph_reg)
                    3'd0:    q2_reg   <= kmul[KQ_FRAC+KQ_WIDTH-1:KQ_FRAC];
                    3'd1:    q3_reg   <= kmul[KQ_FRAC+KQ_WIDTH-1:KQ_FRAC];
                    3'd2:    a_reg    <= {kmul[KQ_FRAC+KQ_WIDTH-1:KQ_FRAC], 2'b00};
                    3'd3:    h3lo_reg <= h3mul;
                    default: h3_reg   <= HW'(h3lo_reg) + (HW'(h3mul) << (CW - 1));
                endcase
            end
            S_EMUL0:
            begin
                if (ent_reg == ENT_DENS)
                begin
                    mag_reg <= MW'({(side_reg ? ma_reg : mb_reg), 16'b0});
                    neg_reg <= 1'b0;
                end
                else
                begin
                    mag_reg <= MW'(eprod_mag);
                    neg_reg <= eprod[2*CW-1];
                end
            end
            S_EMUL1:
            begin
                plo_reg <= plo;
            end
            S_EMUL2:
            begin
                num_reg <= NW'(plo_reg) + (NW'(phi) << ML);
            end
            S_ECHK:
            begin
                rem_reg <= HW'(num_hi);
                nlo_reg <= num_reg[RW-1:0];
                quo_reg <= '0;
            end
            S_EDIV:
            begin
                rem_reg <= dge ? HW'(trial - (HW+1)'(h3_reg)) : HW'(trial);
                nlo_reg <= nlo_reg << 1;
                quo_reg <= quo_next;
            end
            default:
            begin
            end
        endcase

        // rows past the first carry no density term; hold it until the row-0 result is out
        if (state_reg == S_EMUL1 && ent_reg == '0 && row_reg != ROW_FIRST)
        begin
            dens_reg <= '0;
        end
        if (store_en)
        begin
            case (ent_reg)
                3'd0:    mc0_reg  <= store_val;
                3'd1:    mc1_reg  <= store_val;
                3'd2:    mc2_reg  <= store_val;
                3'd3:    jc0_reg  <= store_val;
                3'd4:    jc1_reg  <= store_val;
                3'd5:    jc2_reg  <= store_val;
                default: dens_reg <= store_val[RW-2:0];
            endcase
        end
        if (emit_reg)
        begin
            side_out_reg <= side_reg ^ (row_reg == ROW_FIRST && ent_reg == '0 &&
                                        state_reg == S_H2);
            row_out_reg  <= (row_reg == ROW_FIRST) ? ROW_LAST : row_reg - 1'b1;
            last_out_reg <= (state_reg == S_IDLE);
        end
    end

    assign result_valid  = valid_reg;
    assign node_side     = side_out_reg;
    assign row_index     = row_out_reg;
    assign last_row      = last_out_reg;
    assign moment_inc_c0 = mc0_reg;
    assign moment_inc_c1 = mc1_reg;
    assign moment_inc_c2 = mc2_reg;
    assign jmat_inc_c0   = jc0_reg;
    assign jmat_inc_c1   = jc1_reg;
    assign jmat_inc_c2   = jc2_reg;
    assign density_inc   = dens_reg;

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_last_is_b_row2: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_row |-> node_side && row_index == ROW_LAST)
        else $error("last row flagged on wrong result");

    a_density_row0: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_index != ROW_FIRST |-> density_inc == '0)
        else $error("density increment on a row other than row 0");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_H2 && !side_reg)
        else $error("pair taken from queue outside idle");

endmodule

`default_nettype wire
